### src/msb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msb_pkg
// Shared types and constants for the Moffat seeing blur block.
// ----------------------------------------------------------------------------
package msb_pkg;

  typedef enum logic [3:0] {
    SEQ_IDLE = 4'b0001,
    SEQ_RDIV = 4'b0010,
    SEQ_SQRT = 4'b0100,
    SEQ_PMUL = 4'b1000
  } seq_state_e;

  localparam int unsigned BetaW     = 16;
  localparam int unsigned SeeW      = 16;
  localparam int unsigned ScaleW    = 37;
  localparam int unsigned ExpW      = 31;
  localparam logic [15:0] BetaMin   = 16'd4097;
  localparam logic [15:0] BetaReset = 16'd16384;
  localparam logic [4:0]  RootSteps = 5'd31;
  localparam logic [4:0]  RecipTop  = 5'd28;
  localparam logic [4:0]  LastRoot  = 5'd16;

endpackage

### src/moffat_shape_seeing_blur.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// moffat_shape_seeing_blur
// Blurs a 2x2 elliptical shape matrix with a Moffat seeing kernel.
// ----------------------------------------------------------------------------
// Channel   | Dir | Contents
// s_axis    | in  | tdata: coef_xx, coef_xy, coef_yy, seeing_fwhm
// m_axis    | out | tdata: blurred_xx, blurred_xy, blurred_yy; tuser: shape_status
// cfg_wr    | in  | profile_beta
//
// One beat per cycle while m_axis is not stalled and the sequencer is idle; each beat
// passes through the divider and multiplier chains.
// After reset and after each profile_beta write the exponent sequencer runs its
// reciprocal divide and 16 square roots; s_axis_tready is low while it does.
// A stall on m_axis freezes the whole pipeline; no beat is lost or repeated.
// ----------------------------------------------------------------------------
module moffat_shape_seeing_blur #(
  parameter int unsigned COEF_WIDTH = 32
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        cfg_wr_en_i,
  input  logic [msb_pkg::BetaW-1:0]                   cfg_wr_data_i,
  input  logic                                        s_axis_tvalid,
  output logic                                        s_axis_tready,
  // coef_xx, coef_xy, coef_yy, seeing_fwhm
  input  logic [((3*COEF_WIDTH+msb_pkg::SeeW+7)/8)*8-1:0] s_axis_tdata,
  output logic                                        m_axis_tvalid,
  input  logic                                        m_axis_tready,
  // blurred_xx, blurred_xy, blurred_yy
  output logic [((3*COEF_WIDTH+7)/8)*8-1:0]           m_axis_tdata,
  // shape_status
  output logic                                        m_axis_tuser
);

  localparam int unsigned CW   = COEF_WIDTH;
  localparam int unsigned F    = CW - 4;
  localparam int unsigned SW   = msb_pkg::ScaleW;
  localparam int unsigned EW   = msb_pkg::ExpW;
  localparam int unsigned SRW  = 68;
  localparam int unsigned WW   = 3 * CW + 64;
  localparam int unsigned RW   = WW + CW;
  localparam int unsigned MW   = 2 * SW + 2 * CW;
  localparam int unsigned TDO  = ((3 * CW + 7) / 8) * 8;
  localparam int unsigned PLW  = 7 * CW + 3;
  localparam int unsigned NST  = 2 * SW + CW + 7;
  localparam int unsigned OB   = 0;
  localparam int unsigned OA   = CW;
  localparam int unsigned OC   = 2 * CW;
  localparam int unsigned OM   = 3 * CW;
  localparam int unsigned OD   = 4 * CW;
  localparam int unsigned OS   = 6 * CW;
  localparam int unsigned ON   = 7 * CW + 1;
  localparam int unsigned OT   = 7 * CW + 2;

  // ---------------- exponent sequencer ----------------
  msb_pkg::seq_state_e state_q, state_d;
  logic [15:0] beta_q, beta_d, betac;
  logic [16:0] rrem_q, rrem_d, rtry;
  logic [15:0] r_q, r_d;
  logic [4:0]  cnt_q, cnt_d, idx_q, idx_d;
  logic [63:0] sv_q, sv_d, sres_q, sres_d, sbit_q, sbit_d, ssum, res_nx;
  logic [31:0] q_q, q_d, p_q, p_d, p_nx;
  logic [63:0] pprod;
  logic [EW-1:0] e_q, e_d;
  logic [31:0] e_full;

  assign betac  = (beta_q < msb_pkg::BetaMin) ? msb_pkg::BetaMin : beta_q;
  assign rtry   = {rrem_q[15:0], (cnt_q == msb_pkg::RecipTop)};
  assign ssum   = sres_q + sbit_q;
  assign res_nx = (sv_q >= ssum) ? ((sres_q >> 1) + sbit_q) : (sres_q >> 1);
  assign pprod  = 64'(p_q) * 64'(q_q);
  assign p_nx   = r_q[4'(msb_pkg::LastRoot - idx_q)] ? pprod[61:30] : p_q;
  assign e_full = p_nx - 32'h4000_0000;

  always_comb begin
    state_d = state_q;
    beta_d  = beta_q;
    rrem_d  = rrem_q;
    r_d     = r_q;
    cnt_d   = cnt_q;
    idx_d   = idx_q;
    sv_d    = sv_q;
    sres_d  = sres_q;
    sbit_d  = sbit_q;
    q_d     = q_q;
    p_d     = p_q;
    e_d     = e_q;
    case (state_q)
      msb_pkg::SEQ_IDLE: begin
      end
      msb_pkg::SEQ_RDIV: begin
        if (rtry >= {1'b0, betac}) begin
          rrem_d = rtry - {1'b0, betac};
          r_d    = {r_q[14:0], 1'b1};
        end else begin
          rrem_d = rtry;
          r_d    = {r_q[14:0], 1'b0};
        end
        cnt_d = cnt_q - 5'd1;
        if (cnt_q == '0) begin
          state_d = msb_pkg::SEQ_SQRT;
          sv_d    = 64'(q_q) << 30;
          sres_d  = '0;
          sbit_d  = 64'd1 << 62;
          idx_d   = 5'd1;
          p_d     = 32'h4000_0000;
          cnt_d   = msb_pkg::RootSteps;
        end
      end
      msb_pkg::SEQ_SQRT: begin
        if (sv_q >= ssum) sv_d = sv_q - ssum;
        sres_d = res_nx;
        sbit_d = sbit_q >> 2;
        cnt_d  = cnt_q - 5'd1;
        if (cnt_q == '0) begin
          q_d     = res_nx[31:0];
          state_d = msb_pkg::SEQ_PMUL;
        end
      end
      msb_pkg::SEQ_PMUL: begin
        p_d = p_nx;
        if (idx_q == msb_pkg::LastRoot) begin
          e_d     = (e_full[EW-1:0] == '0) ? EW'(1) : e_full[EW-1:0];
          state_d = msb_pkg::SEQ_IDLE;
        end else begin
          idx_d   = idx_q + 5'd1;
          sv_d    = 64'(q_q) << 30;
          sres_d  = '0;
          sbit_d  = 64'd1 << 62;
          cnt_d   = msb_pkg::RootSteps;
          state_d = msb_pkg::SEQ_SQRT;
        end
      end
      default: state_d = msb_pkg::SEQ_IDLE;
    endcase
    if (cfg_wr_en_i) begin
      beta_d  = cfg_wr_data_i;
      state_d = msb_pkg::SEQ_RDIV;
      rrem_d  = '0;
      r_d     = '0;
      cnt_d   = msb_pkg::RecipTop;
      q_d     = 32'h8000_0000;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= msb_pkg::SEQ_RDIV;
      beta_q  <= msb_pkg::BetaReset;
      rrem_q  <= '0;
      r_q     <= '0;
      cnt_q   <= msb_pkg::RecipTop;
      idx_q   <= 5'd1;
      sv_q    <= '0;
      sres_q  <= '0;
      sbit_q  <= '0;
      q_q     <= 32'h8000_0000;
      p_q     <= 32'h4000_0000;
      e_q     <= EW'(1);
    end else begin
      state_q <= state_d;
      beta_q  <= beta_d;
      rrem_q  <= rrem_d;
      r_q     <= r_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      sv_q    <= sv_d;
      sres_q  <= sres_d;
      sbit_q  <= sbit_d;
      q_q     <= q_d;
      p_q     <= p_d;
      e_q     <= e_d;
    end
  end

  // ---------------- pipeline control ----------------
  logic           en, in_acc;
  logic [NST-1:0] vld_q;

  assign en            = !vld_q[NST-1] || m_axis_tready;
  assign s_axis_tready = en && (state_q == msb_pkg::SEQ_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = vld_q[NST-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NST-2:0], in_acc};
    end
  end

  // ---------------- capture and products ----------------
  logic [CW-1:0]   a0_q, b0_q, c0_q, a1_q, b1_q, c1_q, m1_q, mag0;
  logic [15:0]     f0_q;
  logic [2*CW-1:0] ac1_q, bb1_q;
  logic [CW:0]     sum1_q;
  logic [31:0]     f21_q;
  logic            n1_q;

  assign mag0 = b0_q[CW-1] ? (~b0_q + CW'(1)) : b0_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      a0_q   <= s_axis_tdata[CW-1:0];
      b0_q   <= s_axis_tdata[2*CW-1:CW];
      c0_q   <= s_axis_tdata[3*CW-1:2*CW];
      f0_q   <= s_axis_tdata[3*CW+15:3*CW];
      ac1_q  <= (2*CW)'(a0_q) * (2*CW)'(c0_q);
      bb1_q  <= (2*CW)'(mag0) * (2*CW)'(mag0);
      sum1_q <= (CW+1)'(a0_q) + (CW+1)'(c0_q);
      f21_q  <= 32'(f0_q) * 32'(f0_q);
      a1_q   <= a0_q;
      b1_q   <= b0_q;
      c1_q   <= c0_q;
      m1_q   <= mag0;
      n1_q   <= b0_q[CW-1];
    end
  end

  // ---------------- seeing scale divider ----------------
  // Each quotient bit also feeds shift-add products of the scale with the
  // coefficient sum and the determinant, one bit behind.
  logic [SRW-1:0]      srem_q [SW+1];
  logic [SW-1:0]       sq_q   [SW+1];
  logic [PLW-1:0]      spl_q  [SW+1];
  logic [SW+CW:0]      sat_q  [SW+1];
  logic [SW+2*CW-1:0]  sad_q  [SW+1];
  logic                st1;

  assign st1 = (sum1_q == '0) || (ac1_q <= bb1_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      srem_q[0] <= SRW'({f21_q, 30'd0});
      sq_q[0]   <= '0;
      spl_q[0]  <= {st1, n1_q, sum1_q, ac1_q - bb1_q, m1_q, c1_q, a1_q, b1_q};
      sat_q[0]  <= '0;
      sad_q[0]  <= '0;
    end
  end

  for (genvar k = 1; k <= SW; k++) begin : g_sdiv
    logic [SRW:0] trial;
    assign trial = {1'b0, srem_q[k-1]} - ((SRW+1)'(e_q) << (SW - k));
    always_ff @(posedge clk_i) begin
      if (en) begin
        srem_q[k] <= trial[SRW] ? srem_q[k-1] : trial[SRW-1:0];
        sq_q[k]   <= {sq_q[k-1][SW-2:0], !trial[SRW]};
        sat_q[k]  <= (sat_q[k-1] << 1)
                     + (sq_q[k-1][0] ? (SW+CW+1)'(spl_q[k-1][OS +: CW+1]) : '0);
        sad_q[k]  <= (sad_q[k-1] << 1)
                     + (sq_q[k-1][0] ? (SW+2*CW)'(spl_q[k-1][OD +: 2*CW]) : '0);
        spl_q[k]  <= spl_q[k-1];
      end
    end
  end

  // ---------------- scale products ----------------
  logic [MW-1:0]       mac_q [SW+1];
  logic [SW+2*CW-1:0]  msd_q [SW+1];
  logic [SW+CW:0]      mt1_q [SW+1];
  logic [SW-1:0]       ms_q  [SW+1];
  logic [PLW-1:0]      mpl_q [SW+1];
  logic [SW-1:0]       s_fin;

  assign s_fin = sq_q[SW];

  always_ff @(posedge clk_i) begin
    if (en) begin
      mac_q[0] <= '0;
      mt1_q[0] <= (sat_q[SW] << 1)
                  + (s_fin[0] ? (SW+CW+1)'(spl_q[SW][OS +: CW+1]) : '0);
      msd_q[0] <= (sad_q[SW] << 1)
                  + (s_fin[0] ? (SW+2*CW)'(spl_q[SW][OD +: 2*CW]) : '0);
      ms_q[0]  <= s_fin;
      mpl_q[0] <= spl_q[SW];
    end
  end

  for (genvar k = 1; k <= SW; k++) begin : g_smul
    always_ff @(posedge clk_i) begin
      if (en) begin
        mac_q[k] <= (mac_q[k-1] << 1) + (ms_q[k-1][SW-k] ? MW'(msd_q[k-1]) : '0);
        msd_q[k] <= msd_q[k-1];
        mt1_q[k] <= mt1_q[k-1];
        ms_q[k]  <= ms_q[k-1];
        mpl_q[k] <= mpl_q[k-1];
      end
    end
  end

  // ---------------- denominator and numerators ----------------
  logic [PLW-1:0]      pl2_q;
  logic [WW-1:0]       den2_q, nx2_q, ny2_q, nm2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      den2_q <= (WW'(1) << (2*F+32)) + (WW'(mt1_q[SW]) << (F+16)) + WW'(mac_q[SW]);
      nx2_q  <= ((WW'(mpl_q[SW][OA +: CW]) << (F+32)) + (WW'(msd_q[SW]) << 16)) << F;
      ny2_q  <= ((WW'(mpl_q[SW][OC +: CW]) << (F+32)) + (WW'(msd_q[SW]) << 16)) << F;
      nm2_q  <= WW'(mpl_q[SW][OM +: CW]) << (2*F+32);
      pl2_q  <= mpl_q[SW];
    end
  end

  // ---------------- quotient dividers ----------------
  logic [RW-1:0]  drem_q [CW+1][3];
  logic [CW-1:0]  dq_q   [CW+1][3];
  logic [2:0]     dovf_q [CW+1];
  logic [WW-1:0]  dden_q [CW+1];
  logic [PLW-1:0] dpl_q  [CW+1];
  logic [RW-1:0]  den_top;

  assign den_top = RW'(den2_q) << CW;

  always_ff @(posedge clk_i) begin
    if (en) begin
      drem_q[0][0] <= RW'(nx2_q);
      drem_q[0][1] <= RW'(nm2_q);
      drem_q[0][2] <= RW'(ny2_q);
      dq_q[0][0]   <= '0;
      dq_q[0][1]   <= '0;
      dq_q[0][2]   <= '0;
      dovf_q[0]    <= {RW'(ny2_q) >= den_top, RW'(nm2_q) >= den_top,
                       RW'(nx2_q) >= den_top};
      dden_q[0]    <= den2_q;
      dpl_q[0]     <= pl2_q;
    end
  end

  for (genvar k = 1; k <= CW; k++) begin : g_qdiv
    logic [RW:0] trial [3];
    always_comb begin
      for (int j = 0; j < 3; j++) begin
        trial[j] = {1'b0, drem_q[k-1][j]} - ((RW+1)'(dden_q[k-1]) << (CW - k));
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        for (int j = 0; j < 3; j++) begin
          drem_q[k][j] <= trial[j][RW] ? drem_q[k-1][j] : trial[j][RW-1:0];
          dq_q[k][j]   <= {dq_q[k-1][j][CW-2:0], !trial[j][RW]};
        end
        dovf_q[k] <= dovf_q[k-1];
        dden_q[k] <= dden_q[k-1];
        dpl_q[k]  <= dpl_q[k-1];
      end
    end
  end

  // ---------------- saturation and output register ----------------
  logic [CW-1:0]  ox, oy, om, mv, lim, ox_q, oy_q, om_q;
  logic           st_q;
  logic [PLW-1:0] pf;

  assign pf  = dpl_q[CW];
  assign lim = pf[ON] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};

  always_comb begin
    ox = dovf_q[CW][0] ? '1 : dq_q[CW][0];
    oy = dovf_q[CW][2] ? '1 : dq_q[CW][2];
    mv = (dovf_q[CW][1] || (dq_q[CW][1] > lim)) ? lim : dq_q[CW][1];
    om = pf[ON] ? (~mv + CW'(1)) : mv;
    if (pf[OT]) begin
      ox = pf[OA +: CW];
      oy = pf[OC +: CW];
      om = pf[OB +: CW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ox_q <= ox;
      om_q <= om;
      oy_q <= oy;
      st_q <= pf[OT];
    end
  end

  assign m_axis_tdata = TDO'({oy_q, om_q, ox_q});
  assign m_axis_tuser = st_q;

`ifndef SYNTHESIS
  a_busy_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != msb_pkg::SEQ_IDLE) |-> !s_axis_tready)
    else $error("input taken while exponent sequencer busy");
  a_beat_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> vld_q[0])
    else $error("accepted beat missing from first stage");
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(vld_q))
    else $error("pipeline moved during output stall");
  a_exp_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == msb_pkg::SEQ_IDLE) |-> (e_q != '0))
    else $error("zero exponent term while idle");
`endif

endmodule

### verif/moffat_shape_seeing_blur_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// moffat_shape_seeing_blur_tb
// Self-checking bench for the Moffat seeing blur block. A directed table of
// shape matrices is followed by random beats under several profile_beta
// settings. Each accepted input beat is predicted with wide integer math, or
// taken from the directed table, and compared field by field with the output beats, in order, under random
// idling on both sides.
// ----------------------------------------------------------------------------
module moffat_shape_seeing_blur_tb;

  localparam int unsigned CW    = 32;
  localparam int unsigned FB    = CW - 4;
  localparam int unsigned LIMIT = 600000;

  typedef logic [255:0] wide_t;

  typedef struct packed {
    logic [CW-1:0] xx;
    logic [CW-1:0] xy;
    logic [CW-1:0] yy;
    logic          st;
  } blur_t;

  typedef struct {
    logic [CW-1:0] xx;
    logic [CW-1:0] xy;
    logic [CW-1:0] yy;
    logic [15:0]   fwhm;
    bit            typed;
    blur_t         res;
  } row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_wr_en_i = 1'b0;
  logic [15:0]        cfg_wr_data_i = '0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [111:0]       s_axis_tdata = '0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [95:0]        m_axis_tdata;
  logic               m_axis_tuser;

  blur_t       blur_due[$];
  row_t        shape_rows[$];
  logic [15:0] beta_now = msb_pkg::BetaReset;
  int          mismatches = 0;
  int unsigned cycles = 0;
  bit          send_idle = 1'b1;
  bit          recv_idle = 1'b1;
  bit          hold_req = 1'b0;

  moffat_shape_seeing_blur #(.COEF_WIDTH(CW)) dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic logic [63:0] isqrt(input logic [63:0] v);
    logic [63:0] res, b;
    res = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] seeing_scale(input logic [15:0] beta,
                                               input logic [15:0] fwhm);
    logic [63:0] r, q, p, e, ff;
    logic [15:0] bc;
    bc = (beta < msb_pkg::BetaMin) ? msb_pkg::BetaMin : beta;
    r = 64'd268435456 / 64'(bc);
    q = 64'd1 << 31;
    p = 64'd1 << 30;
    for (int i = 1; i <= 16; i++) begin
      q = isqrt(q << 30);
      if (r[16-i]) p = (p * q) >> 30;
    end
    e = p - (64'd1 << 30);
    if (e == 0) e = 1;
    ff = 64'(fwhm) * 64'(fwhm);
    return (ff << 30) / e;
  endfunction

  function automatic blur_t blur_shape(input logic [CW-1:0] xx, input logic [CW-1:0] xy,
                                       input logic [CW-1:0] yy, input logic [15:0] fwhm);
    blur_t o;
    wide_t a, c, mag, s, d, den, t, q, half, mask;
    logic [CW-1:0] nxy;
    bit neg;
    mask = (wide_t'(1) << CW) - 1;
    half = wide_t'(1) << (CW - 1);
    a = wide_t'(xx);
    c = wide_t'(yy);
    neg = xy[CW-1];
    nxy = -xy;
    mag = neg ? wide_t'(nxy) : wide_t'(xy);
    if (neg && mag == 0) mag = half;
    o = '{xx, xy, yy, 1'b1};
    if (a + c == 0 || a * c <= mag * mag) return o;
    d = a * c - mag * mag;
    s = wide_t'(seeing_scale(beta_now, fwhm));
    den = (wide_t'(1) << (2 * FB + 32)) + ((s * (a + c)) << (FB + 16)) + s * s * d;
    t = (s * d) << 16;
    q = (((a << (FB + 32)) + t) << FB) / den;
    o.xx = (q > mask) ? mask[CW-1:0] : q[CW-1:0];
    q = (((c << (FB + 32)) + t) << FB) / den;
    o.yy = (q > mask) ? mask[CW-1:0] : q[CW-1:0];
    q = (mag << (2 * FB + 32)) / den;
    if (neg) begin
      if (q > half) q = half;
      o.xy = -q[CW-1:0];
    end else begin
      if (q > half - 1) q = half - 1;
      o.xy = q[CW-1:0];
    end
    o.st = 1'b0;
    return o;
  endfunction

  task automatic add_row(input logic [CW-1:0] xx, input logic [CW-1:0] xy,
                         input logic [CW-1:0] yy, input logic [15:0] fwhm,
                         input bit typed, input blur_t res);
    row_t r;
    r = '{xx, xy, yy, fwhm, typed, res};
    shape_rows.push_back(r);
  endtask

  task automatic send_beat(input row_t r);
    if (send_idle && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {r.fwhm, r.yy, r.xy, r.xx};
    do @(posedge clk_i); while (!s_axis_tready);
    blur_due.push_back(r.typed ? r.res : blur_shape(r.xx, r.xy, r.yy, r.fwhm));
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (blur_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_beta(input logic [15:0] v);
    cfg_wr_en_i   <= 1'b1;
    cfg_wr_data_i <= v;
    @(posedge clk_i);
    cfg_wr_en_i   <= 1'b0;
    beta_now = v;
  endtask

  function automatic row_t random_row();
    row_t r;
    int unsigned mode;
    logic [63:0] mn, mag;
    mode = $urandom_range(0, 9);
    r.typed = 1'b0;
    r.xx = $urandom;
    r.yy = $urandom;
    r.xy = $urandom;
    r.fwhm = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 2047));
    if (mode >= 1) begin
      if (mode < 5) begin
        r.xx = r.xx >> $urandom_range(0, 31);
        r.yy = r.yy >> $urandom_range(0, 31);
      end
      mn = (r.xx < r.yy) ? r.xx : r.yy;
      mag = $urandom_range(0, (mn > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : 32'(mn));
      r.xy = $urandom_range(0, 1) ? -mag[CW-1:0] : mag[CW-1:0];
    end
    return r;
  endfunction

  initial begin
    forever begin
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (400) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (recv_idle && $urandom_range(0, 7) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    blur_t got, want;
    if (m_axis_tvalid && m_axis_tready) begin
      got = '{m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tdata[95:64], m_axis_tuser};
      if (blur_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat xx=%h xy=%h yy=%h st=%b",
                                       got.xx, got.xy, got.yy, got.st);
      end else begin
        want = blur_due.pop_front();
        if (got != want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp xx=%h xy=%h yy=%h st=%b got xx=%h xy=%h yy=%h st=%b",
                     want.xx, want.xy, want.yy, want.st, got.xx, got.xy, got.yy, got.st);
        end
      end
    end
  end

  initial begin
    logic [15:0] betas[6];
    int          n;
    betas = '{msb_pkg::BetaReset, 16'd4097, 16'd65535, 16'd0, 16'd0, 16'd0};
    betas[3] = 16'($urandom_range(0, 4096));
    betas[4] = 16'($urandom_range(4097, 65535));
    betas[5] = 16'($urandom_range(4097, 20000));

    // not positive definite: pass through
    add_row(0, 0, 0, 16'h0100, 1, '{0, 0, 0, 1});
    add_row(32'h1000_0000, 32'h8000_0000, 32'h1000_0000, 16'hFFFF, 1,
            '{32'h1000_0000, 32'h8000_0000, 32'h1000_0000, 1});
    add_row(32'h1000_0000, 32'h1000_0000, 32'h1000_0000, 16'h0200, 1,
            '{32'h1000_0000, 32'h1000_0000, 32'h1000_0000, 1});
    add_row(32'h1000_0000, 32'hF000_0000, 32'h1000_0000, 16'h0200, 1,
            '{32'h1000_0000, 32'hF000_0000, 32'h1000_0000, 1});
    add_row(32'hFFFF_FFFF, 0, 0, 16'h0100, 1, '{32'hFFFF_FFFF, 0, 0, 1});
    add_row(0, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 16'h0100, 1, '{0, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1});
    // zero seeing: unchanged
    add_row(32'h1000_0000, 0, 32'h1000_0000, 0, 1, '{32'h1000_0000, 0, 32'h1000_0000, 0});
    add_row(32'hFFFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 0, 1,
            '{32'hFFFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 0});
    // predicted
    add_row(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 0, '{0, 0, 0, 0});
    add_row(32'hFFFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 16'h0001, 0, '{0, 0, 0, 0});
    add_row(32'h1000_0000, 0, 32'h1000_0000, 16'h0100, 0, '{0, 0, 0, 0});
    add_row(32'h1000_0000, 0, 32'h4000_0000, 16'h0300, 0, '{0, 0, 0, 0});
    add_row(32'h0000_0001, 0, 32'h0000_0001, 16'hFFFF, 0, '{0, 0, 0, 0});
    add_row(32'h2000_0000, 32'hF800_0000, 32'h1800_0000, 16'h0280, 0, '{0, 0, 0, 0});
    add_row(32'h2000_0000, 32'h0800_0000, 32'h1800_0000, 16'h0001, 0, '{0, 0, 0, 0});

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (shape_rows[i]) send_beat(shape_rows[i]);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      if (ph > 0) write_beta(betas[ph]);
      n = (ph == 0) ? 160 : 215;
      for (int i = 0; i < n; i++) begin
        if (ph == 5 && i == n - 150) begin
          send_idle = 1'b0;
          recv_idle = 1'b0;
        end
        if (ph == 1 && i == 20) hold_req = 1'b1;
        send_beat(random_row());
      end
      drain();
    end

    repeat (100) @(posedge clk_i);
    if (mismatches == 0 && blur_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
